// ===== rtl/core/gng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gng_pkg - grid neighbor generator shared definitions
// Sizes, codes, result record and neighbor offset tables.
// ----------------------------------------------------------------------------
package gng_pkg;

    // Default geometry and cost storage width
    localparam int GNG_MAX_COLS  = 64;
    localparam int GNG_MAX_ROWS  = 64;
    localparam int GNG_COST_BITS = 8;

    // Fixed field widths of the channels
    localparam int COORD_W     = 6;
    localparam int COORD_REACH = 64;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int KIND_W      = 2;
    localparam int DIR_W       = 3;
    localparam int OUT_COST_W  = 8;
    localparam int MODE_W      = 2;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_SET_WALK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_COST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

    // Diagonal modes
    localparam logic [MODE_W-1:0] DIAG_ALWAYS = 2'd0;
    localparam logic [MODE_W-1:0] DIAG_NEVER  = 2'd1;
    localparam logic [MODE_W-1:0] DIAG_BOTH   = 2'd2;
    localparam logic [MODE_W-1:0] DIAG_EITHER = 2'd3;

    // Directions in listing order
    localparam logic [DIR_W-1:0] DIR_UP        = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT     = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN      = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT      = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UPLEFT    = 3'd4;
    localparam logic [DIR_W-1:0] DIR_UPRIGHT   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DOWNRIGHT = 3'd6;
    localparam logic [DIR_W-1:0] DIR_DOWNLEFT  = 3'd7;

    typedef struct packed {
        logic                  found;
        logic [COORD_W-1:0]    nx;
        logic [COORD_W-1:0]    ny;
        logic [OUT_COST_W-1:0] cost;
        logic [DIR_W-1:0]      dir;
        logic                  oor;
        logic                  last;
    } t_result;

    // Column offset as a 7-bit two's complement step
    function automatic logic [COORD_W:0] gng_off_x(input logic [DIR_W-1:0] dir);
        logic [COORD_W:0] off;
        case (dir)
            DIR_RIGHT, DIR_UPRIGHT, DIR_DOWNRIGHT: off = 7'h01;
            DIR_LEFT, DIR_UPLEFT, DIR_DOWNLEFT:    off = 7'h7F;
            default:                               off = 7'h00;
        endcase
        return off;
    endfunction

    // Row offset as a 7-bit two's complement step (up is y + 1)
    function automatic logic [COORD_W:0] gng_off_y(input logic [DIR_W-1:0] dir);
        logic [COORD_W:0] off;
        case (dir)
            DIR_UP, DIR_UPLEFT, DIR_UPRIGHT:        off = 7'h01;
            DIR_DOWN, DIR_DOWNRIGHT, DIR_DOWNLEFT:  off = 7'h7F;
            default:                                off = 7'h00;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/core/grid_neighbor_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbor_generator_unit - pathfinding grid with neighbor listing
// Holds a walkable bit and a terrain cost per cell; writes cells and lists
// the walkable in-bounds neighbors of a queried cell, diagonals by mode.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   in       | input     | i_in_valid / o_in_ready   | kind, cell x/y, walk, cost
//   out      | output    | o_out_valid / i_out_ready | found, neighbor x/y/cost,
//            |           |                           | direction, out_of_range, last
//   cfg      | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// Sequence: a write, an unused kind or a query of a cell outside the grid is
//   accepted and then handed off. A query inside the grid is accepted, then
//   steps through the directions in order: it skips one that is off-grid or
//   not allowed and reads the maps for and evaluates one that is; then it is
//   handed off. The maps have one read port, the sequencer one direction a step.
// Reset: both maps are swept one cell a cycle over all MAX_COLS * MAX_ROWS cells
//   (4096 at the defaults); o_in_ready stays low meanwhile, cfg writes land.
// Stalls: a result waits in the output register; the sequencer holds one found
//   neighbor back so the last flag is known. The scan waits only when a neighbor is
//   found while that slot and the output register are full; the hand-off waits for the latter.
// ----------------------------------------------------------------------------
module grid_neighbor_generator_unit #(
    parameter int MAX_COLS  = gng_pkg::GNG_MAX_COLS,
    parameter int MAX_ROWS  = gng_pkg::GNG_MAX_ROWS,
    parameter int COST_BITS = gng_pkg::GNG_COST_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transaction
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [gng_pkg::KIND_W-1:0]        i_kind,
    input  logic [gng_pkg::COORD_W-1:0]       i_cell_x,
    input  logic [gng_pkg::COORD_W-1:0]       i_cell_y,
    input  logic                              i_walk_value,
    input  logic [gng_pkg::OUT_COST_W-1:0]    i_cost_value,
    // result transaction
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [gng_pkg::COORD_W-1:0]       o_neighbor_x,
    output logic [gng_pkg::COORD_W-1:0]       o_neighbor_y,
    output logic [gng_pkg::OUT_COST_W-1:0]    o_neighbor_cost,
    output logic [gng_pkg::DIR_W-1:0]         o_direction,
    output logic                              o_out_of_range,
    output logic                              o_last,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [gng_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gng_pkg::CFG_W-1:0]         i_cfg_data
);

    import gng_pkg::*;

    // Grid size in use is limited by the storage and by the coordinate reach
    localparam int COL_LIM = (MAX_COLS < COORD_REACH) ? MAX_COLS : COORD_REACH;
    localparam int ROW_LIM = (MAX_ROWS < COORD_REACH) ? MAX_ROWS : COORD_REACH;
    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(DEPTH);
    // Cost bits that survive both the store and the 8-bit result
    localparam int CW      = (COST_BITS < OUT_COST_W) ? COST_BITS : OUT_COST_W;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [MODE_W-1:0]   r_mode;
    logic [CFG_W-1:0]    r_cols;
    logic [CFG_W-1:0]    r_rows;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    logic [DIR_W-1:0]    r_dir, n_dir;
    logic [3:0]          r_side, n_side;
    t_result             r_pend, n_pend;
    logic                r_have_pend, n_have_pend;
    t_result             r_out;
    logic                r_out_valid;

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    logic                  w_accept;
    logic                  w_in_inside;
    logic [ADDR_W-1:0]     w_in_addr;
    logic [COORD_W:0]      w_nx;
    logic [COORD_W:0]      w_ny;
    logic                  w_nb_inside;
    logic                  w_side_a;
    logic                  w_side_b;
    logic                  w_diag_ok;
    logic                  w_eligible;
    logic [ADDR_W-1:0]     w_nb_addr;
    logic                  w_out_free;
    logic                  w_clearing;
    logic                  w_walk_we;
    logic                  w_cost_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [0:0]            w_walk_wdata;
    logic [COST_BITS-1:0]  w_cost_wdata;
    logic                  w_re;
    logic [0:0]            w_rd_walk;
    logic [COST_BITS-1:0]  w_rd_cost;
    t_result               w_new;
    logic                  w_push;
    t_result               w_push_val;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_clearing  = (r_state == S_CLEAR);

    assign w_in_inside = ({1'b0, i_cell_x} < r_cols) && ({1'b0, i_cell_y} < r_rows);
    assign w_in_addr   = ADDR_W'(32'(i_cell_y) * MAX_COLS) + ADDR_W'(i_cell_x);

    // Neighbor position: a step below zero wraps to 127 and fails the bound
    assign w_nx        = {1'b0, r_x} + gng_off_x(r_dir);
    assign w_ny        = {1'b0, r_y} + gng_off_y(r_dir);
    assign w_nb_inside = (w_nx < r_cols) && (w_ny < r_rows);
    assign w_nb_addr   = ADDR_W'(32'(w_ny[COORD_W-1:0]) * MAX_COLS)
                       + ADDR_W'(w_nx[COORD_W-1:0]);

    // Sides next to a diagonal: the one before it in order and the one at its index
    assign w_side_a = r_side[r_dir[1:0] - 2'd1];
    assign w_side_b = r_side[r_dir[1:0]];

    always_comb begin
        case (r_mode)
            DIAG_ALWAYS: w_diag_ok = 1'b1;
            DIAG_BOTH:   w_diag_ok = w_side_a && w_side_b;
            DIAG_EITHER: w_diag_ok = w_side_a || w_side_b;
            default:     w_diag_ok = 1'b0;
        endcase
    end

    assign w_eligible = w_nb_inside && (!r_dir[2] || w_diag_ok);

    // Map port: the reset sweep owns the write side until it is done
    assign w_walk_we    = w_clearing ||
                          (w_accept && w_in_inside && (i_kind == KIND_SET_WALK));
    assign w_cost_we    = w_clearing ||
                          (w_accept && w_in_inside && (i_kind == KIND_SET_COST));
    assign w_waddr      = w_clearing ? r_clr_addr : w_in_addr;
    assign w_walk_wdata = w_clearing ? 1'b1 : i_walk_value;
    assign w_cost_wdata = w_clearing ? '0 : COST_BITS'(i_cost_value[CW-1:0]);
    assign w_re         = (r_state == S_ISSUE) && w_eligible;

    gng_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_walk_map (
        .i_clk   (i_clk),
        .i_we    (w_walk_we),
        .i_waddr (w_waddr),
        .i_wdata (w_walk_wdata),
        .i_re    (w_re),
        .i_raddr (w_nb_addr),
        .o_rdata (w_rd_walk)
    );

    gng_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (DEPTH)
    ) u_cost_map (
        .i_clk   (i_clk),
        .i_we    (w_cost_we),
        .i_waddr (w_waddr),
        .i_wdata (w_cost_wdata),
        .i_re    (w_re),
        .i_raddr (w_nb_addr),
        .o_rdata (w_rd_cost)
    );

    // Result for the neighbor that was just read
    always_comb begin
        w_new       = '0;
        w_new.found = 1'b1;
        w_new.nx    = w_nx[COORD_W-1:0];
        w_new.ny    = w_ny[COORD_W-1:0];
        w_new.cost  = OUT_COST_W'(w_rd_cost[CW-1:0]);
        w_new.dir   = r_dir;
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_x         = r_x;
        n_y         = r_y;
        n_dir       = r_dir;
        n_side      = r_side;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        w_push      = 1'b0;
        w_push_val  = r_pend;

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (w_accept) begin
                    // writes, unused kinds and queries outside the grid end in a single empty result
                    n_pend      = '0;
                    n_have_pend = 1'b1;
                    n_state     = S_FLUSH;
                    case (i_kind)
                        KIND_SET_WALK, KIND_SET_COST: begin
                            n_pend.oor = !w_in_inside;
                        end
                        KIND_QUERY: begin
                            if (w_in_inside) begin
                                n_x         = i_cell_x;
                                n_y         = i_cell_y;
                                n_dir       = DIR_UP;
                                n_side      = '0;
                                n_have_pend = 1'b0;
                                n_state     = S_ISSUE;
                            end else begin
                                n_pend.oor = 1'b1;
                            end
                        end
                        default: begin
                            n_pend = '0;
                        end
                    endcase
                end
            end

            S_ISSUE: begin
                if (w_eligible) begin
                    n_state = S_EVAL;
                end else if (r_dir == DIR_DOWNLEFT) begin
                    n_state = S_FLUSH;
                end else begin
                    n_dir = r_dir + 1'b1;
                end
            end

            S_EVAL: begin
                // hold while a found neighbor has nowhere to go
                if (!(w_rd_walk[0] && r_have_pend && !w_out_free)) begin
                    if (!r_dir[2]) begin
                        n_side[r_dir[1:0]] = w_rd_walk[0];
                    end
                    if (w_rd_walk[0]) begin
                        w_push      = r_have_pend;
                        w_push_val  = r_pend;
                        n_pend      = w_new;
                        n_have_pend = 1'b1;
                    end
                    if (r_dir == DIR_DOWNLEFT) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_dir   = r_dir + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end

            S_FLUSH: begin
                if (w_out_free) begin
                    w_push          = 1'b1;
                    w_push_val      = r_have_pend ? r_pend : '0;
                    w_push_val.last = 1'b1;
                    n_have_pend     = 1'b0;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= DIAG_NEVER;
            r_cols      <= CFG_W'(COL_LIM);
            r_rows      <= CFG_W'(ROW_LIM);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_have_pend <= n_have_pend;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // clamp the grid size once, at the write
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIAG_MODE: begin
                        r_mode <= i_cfg_data[MODE_W-1:0];
                    end
                    CFG_GRID_WIDTH: begin
                        r_cols <= (32'(i_cfg_data) > COL_LIM) ? CFG_W'(COL_LIM) : i_cfg_data;
                    end
                    CFG_GRID_HEIGHT: begin
                        r_rows <= (32'(i_cfg_data) > ROW_LIM) ? CFG_W'(ROW_LIM) : i_cfg_data;
                    end
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_dir  <= n_dir;
        r_side <= n_side;
        r_pend <= n_pend;
        if (w_push) begin
            r_out <= w_push_val;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out.found;
    assign o_neighbor_x    = r_out.nx;
    assign o_neighbor_y    = r_out.ny;
    assign o_neighbor_cost = r_out.cost;
    assign o_direction     = r_out.dir;
    assign o_out_of_range  = r_out.oor;
    assign o_last          = r_out.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free)
        else $error("result pushed over an untaken result");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> r_out.last)
        else $error("empty result not marked last");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> !r_out.oor)
        else $error("neighbor result flagged out of range");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_ISSUE || $past(r_state) == S_EVAL))
        else $error("map data used without a read");

    a_no_read_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> !(w_walk_we || w_cost_we))
        else $error("map read and write in the same cycle");

endmodule

// ===== rtl/core/gng_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gng_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
